// ===== hw/rtl/lpbrq_pkg.sv =====
// Shared types and constants for the length-prefixed byte ring queue.
// Holds the result status codes and the controller/datapath command and status structs.
// No dependencies.
package lpbrq_pkg;

	// Fixed field widths of the item and result ports.
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned LEN_W    = 12;
	localparam int unsigned STATUS_W = 3;
	localparam int unsigned USED_W   = 13;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_PUSHED    = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
	localparam logic [STATUS_W-1:0] ST_ZERO      = 3'd2;
	localparam logic [STATUS_W-1:0] ST_POPPED    = 3'd3;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;
	localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 3'd5;

	// Mode codes of an input item.
	localparam logic MODE_PUSH = 1'b0;
	localparam logic MODE_POP  = 1'b1;

	// Commands from the controller to the datapath; at most one work command per cycle.
	typedef struct packed {
		logic capture;
		logic push_cont;
		logic push_zero;
		logic push_drop;
		logic push_open;
		logic cnt_clr;
		logic hdr_wr;
		logic push_first;
		logic pop_empty;
		logic hdr_rd;
		logic pop_skip;
		logic pop_load;
		logic pop_rd;
		logic pop_take;
		logic out_load;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_pop;
		logic push_active;
		logic len_zero;
		logic no_room;
		logic pop_active;
		logic ring_empty;
		logic hdr_wr_done;
		logic hdr_rd_done;
		logic size_bad;
		logic out_busy;
	} sts_t;

	// Header byte idx of a message length, little-endian.
	function automatic logic [BYTE_W-1:0] hdr_byte(input logic [LEN_W-1:0] len,
	                                              input logic [1:0] idx);
		logic [BYTE_W-1:0] b;
		begin
			unique case (idx)
				2'd0: b = len[7:0];
				2'd1: b = {4'b0000, len[11:8]};
				default: b = '0;
			endcase
			return b;
		end
	endfunction

endpackage

// ===== hw/rtl/lpbrq_ram.sv =====
// Generic single-port RAM with registered read data.
// One write or one read per cycle. No dependencies.
module lpbrq_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4097
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write, or read into the output register.
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata <= mem_q[addr];
			end
		end
	end

endmodule

// ===== hw/rtl/lpbrq_ctrl.sv =====
// Controller state machine of the length-prefixed byte ring queue.
// Depends on lpbrq_pkg for the command and status structs.
module lpbrq_ctrl
	import lpbrq_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_DECIDE  = 4'd1;
	localparam logic [3:0] S_HDR_WR  = 4'd2;
	localparam logic [3:0] S_DATA_WR = 4'd3;
	localparam logic [3:0] S_HDR_RD  = 4'd4;
	localparam logic [3:0] S_CHECK   = 4'd5;
	localparam logic [3:0] S_RD_DATA = 4'd6;
	localparam logic [3:0] S_RD_TAKE = 4'd7;
	localparam logic [3:0] S_DONE    = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_nx;

	// A new item is taken only when idle and the result register is free by then.
	assign in_ready = (state_q == S_IDLE) && !sts.out_busy;

	// Next state and command decode.
	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && in_ready) begin
					cmd.capture = 1'b1;
					state_nx    = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (!sts.is_pop) begin
					priority if (sts.push_active) begin
						cmd.push_cont = 1'b1;
						state_nx      = S_DONE;
					end else if (sts.len_zero) begin
						cmd.push_zero = 1'b1;
						state_nx      = S_DONE;
					end else if (sts.no_room) begin
						cmd.push_drop = 1'b1;
						state_nx      = S_DONE;
					end else begin
						cmd.push_open = 1'b1;
						cmd.cnt_clr   = 1'b1;
						state_nx      = S_HDR_WR;
					end
				end else begin
					priority if (sts.pop_active) begin
						cmd.pop_rd = 1'b1;
						state_nx   = S_RD_TAKE;
					end else if (sts.ring_empty) begin
						cmd.pop_empty = 1'b1;
						state_nx      = S_DONE;
					end else begin
						cmd.cnt_clr = 1'b1;
						state_nx    = S_HDR_RD;
					end
				end
			end
			S_HDR_WR: begin
				cmd.hdr_wr = 1'b1;
				if (sts.hdr_wr_done) begin
					state_nx = S_DATA_WR;
				end
			end
			S_DATA_WR: begin
				cmd.push_first = 1'b1;
				state_nx       = S_DONE;
			end
			S_HDR_RD: begin
				cmd.hdr_rd = 1'b1;
				if (sts.hdr_rd_done) begin
					state_nx = S_CHECK;
				end
			end
			S_CHECK: begin
				if (sts.size_bad) begin
					cmd.pop_skip = 1'b1;
					state_nx     = S_DONE;
				end else begin
					cmd.pop_load = 1'b1;
					state_nx     = S_RD_DATA;
				end
			end
			S_RD_DATA: begin
				cmd.pop_rd = 1'b1;
				state_nx   = S_RD_TAKE;
			end
			S_RD_TAKE: begin
				cmd.pop_take = 1'b1;
				state_nx     = S_DONE;
			end
			S_DONE: begin
				cmd.out_load = 1'b1;
				state_nx     = S_IDLE;
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

endmodule

// ===== hw/rtl/lpbrq_dp.sv =====
// Datapath of the length-prefixed byte ring queue: pointers, counters, ring memory, result register.
// Depends on lpbrq_pkg and lpbrq_ram.
module lpbrq_dp
	import lpbrq_pkg::*;
#(
	parameter int unsigned CAPACITY     = 4096,
	parameter int unsigned HEADER_BYTES = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	output sts_t                sts,
	input  logic                mode,
	input  logic [BYTE_W-1:0]   data_in,
	input  logic [LEN_W-1:0]    msg_length,
	input  logic [LEN_W-1:0]    dest_capacity,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [BYTE_W-1:0]   data_out,
	output logic [STATUS_W-1:0] status,
	output logic                last,
	output logic [USED_W-1:0]   used_bytes
);

	localparam int unsigned RING  = CAPACITY + 1;
	localparam int unsigned PTR_W = $clog2(RING);
	localparam int unsigned WIDE  = (PTR_W > LEN_W) ? PTR_W : LEN_W;
	localparam int unsigned ADD_W = WIDE + 1;
	localparam int unsigned SUM_W = WIDE + 2;
	localparam int unsigned CNT_W = $clog2(HEADER_BYTES + 1);

	// Control state.
	logic [PTR_W-1:0] work_ptr_q, commit_ptr_q, read_ptr_q;
	logic [LEN_W-1:0] push_left_q, pop_left_q;
	logic             dropping_q;
	logic [CNT_W-1:0] hdr_cnt_q;
	logic             out_valid_q;

	// Captured item and working values.
	logic              mode_q;
	logic [BYTE_W-1:0] data_q;
	logic [LEN_W-1:0]  len_q, cap_q, size_q;
	logic [STATUS_W-1:0] res_status_q;
	logic              res_last_q;
	logic [BYTE_W-1:0] res_data_q;
	logic [BYTE_W-1:0] out_data_q;
	logic [STATUS_W-1:0] out_status_q;
	logic              out_last_q;
	logic [USED_W-1:0] out_used_q;

	logic [PTR_W-1:0]  work_nx, read_nx, skip_ptr;
	logic [ADD_W-1:0]  skip_sum;
	logic [PTR_W:0]    used_wide;
	logic [PTR_W-1:0]  used;
	logic [SUM_W-1:0]  need;
	logic              hdr_issue;
	logic [1:0]        wr_idx, rd_idx;
	logic              ram_en, ram_we;
	logic [PTR_W-1:0]  ram_addr;
	logic [BYTE_W-1:0] ram_wdata, ram_rdata;

	// Pointer steps, all wrapping over the ring cells.
	assign work_nx  = (work_ptr_q == PTR_W'(RING - 1)) ? '0 : work_ptr_q + 1'b1;
	assign read_nx  = (read_ptr_q == PTR_W'(RING - 1)) ? '0 : read_ptr_q + 1'b1;
	assign skip_sum = ADD_W'(read_ptr_q) + ADD_W'(size_q);
	assign skip_ptr = (skip_sum >= ADD_W'(RING)) ? PTR_W'(skip_sum - ADD_W'(RING))
	                                             : PTR_W'(skip_sum);

	// Committed byte count between the read and commit pointers.
	assign used_wide = {1'b0, commit_ptr_q} - {1'b0, read_ptr_q}
	                 + ((commit_ptr_q < read_ptr_q) ? (PTR_W+1)'(RING) : '0);
	assign used      = used_wide[PTR_W-1:0];
	assign need      = SUM_W'(HEADER_BYTES) + SUM_W'(len_q) + SUM_W'(used);

	assign hdr_issue = hdr_cnt_q < CNT_W'(HEADER_BYTES);
	assign wr_idx    = hdr_cnt_q[1:0];
	assign rd_idx    = 2'(hdr_cnt_q - CNT_W'(1));

	// Status toward the controller.
	always_comb begin
		sts.is_pop      = (mode_q == MODE_POP);
		sts.push_active = (push_left_q != '0);
		sts.len_zero    = (len_q == '0);
		sts.no_room     = need > SUM_W'(CAPACITY);
		sts.pop_active  = (pop_left_q != '0);
		sts.ring_empty  = (used == '0);
		sts.hdr_wr_done = (hdr_cnt_q == CNT_W'(HEADER_BYTES - 1));
		sts.hdr_rd_done = (hdr_cnt_q == CNT_W'(HEADER_BYTES));
		sts.size_bad    = (size_q > cap_q) || (size_q == '0);
		sts.out_busy    = out_valid_q && !out_ready;
	end

	// Ring memory port: writes at the working pointer, reads at the read pointer.
	assign ram_we    = cmd.hdr_wr || cmd.push_first || (cmd.push_cont && !dropping_q);
	assign ram_en    = ram_we || cmd.pop_rd || (cmd.hdr_rd && hdr_issue);
	assign ram_addr  = ram_we ? work_ptr_q : read_ptr_q;
	assign ram_wdata = cmd.hdr_wr ? hdr_byte(len_q, wr_idx) : data_q;

	lpbrq_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (RING)
	) u_ring (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// Pointers, byte counters and handshake state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_ptr_q   <= '0;
			commit_ptr_q <= '0;
			read_ptr_q   <= '0;
			push_left_q  <= '0;
			pop_left_q   <= '0;
			dropping_q   <= 1'b0;
			hdr_cnt_q    <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.push_cont) begin
				push_left_q <= push_left_q - 1'b1;
				if (!dropping_q) begin
					work_ptr_q <= work_nx;
				end
				if (push_left_q == LEN_W'(1)) begin
					if (!dropping_q) begin
						commit_ptr_q <= work_nx;
					end
					dropping_q <= 1'b0;
				end
			end
			if (cmd.push_drop) begin
				push_left_q <= len_q - 1'b1;
				dropping_q  <= (len_q != LEN_W'(1));
			end
			if (cmd.push_open) begin
				push_left_q <= len_q - 1'b1;
				work_ptr_q  <= commit_ptr_q;
			end
			if (cmd.cnt_clr) begin
				hdr_cnt_q <= '0;
			end
			if (cmd.hdr_wr) begin
				work_ptr_q <= work_nx;
				hdr_cnt_q  <= hdr_cnt_q + 1'b1;
			end
			if (cmd.push_first) begin
				work_ptr_q <= work_nx;
				if (push_left_q == '0) begin
					commit_ptr_q <= work_nx;
				end
			end
			if (cmd.hdr_rd) begin
				hdr_cnt_q <= hdr_cnt_q + 1'b1;
				if (hdr_issue) begin
					read_ptr_q <= read_nx;
				end
			end
			if (cmd.pop_skip) begin
				read_ptr_q <= skip_ptr;
			end
			if (cmd.pop_load) begin
				pop_left_q <= size_q;
			end
			if (cmd.pop_rd) begin
				read_ptr_q <= read_nx;
				pop_left_q <= pop_left_q - 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Item capture, header assembly and result fields.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q     <= mode;
			data_q     <= data_in;
			len_q      <= msg_length;
			cap_q      <= dest_capacity;
			res_data_q <= '0;
			res_last_q <= 1'b0;
		end
		if (cmd.hdr_rd && (hdr_cnt_q != '0)) begin
			unique case (rd_idx)
				2'd0: size_q[7:0]  <= ram_rdata;
				2'd1: size_q[11:8] <= ram_rdata[3:0];
				default: ;
			endcase
		end
		if (cmd.push_cont) begin
			res_status_q <= dropping_q ? ST_FULL : ST_PUSHED;
			res_last_q   <= (push_left_q == LEN_W'(1));
		end
		if (cmd.push_zero) begin
			res_status_q <= ST_ZERO;
			res_last_q   <= 1'b1;
		end
		if (cmd.push_drop) begin
			res_status_q <= ST_FULL;
			res_last_q   <= (len_q == LEN_W'(1));
		end
		if (cmd.push_first) begin
			res_status_q <= ST_PUSHED;
			res_last_q   <= (push_left_q == '0);
		end
		if (cmd.pop_empty) begin
			res_status_q <= ST_EMPTY;
		end
		if (cmd.pop_skip) begin
			res_status_q <= ST_TOO_LARGE;
		end
		if (cmd.pop_take) begin
			res_status_q <= ST_POPPED;
			res_data_q   <= ram_rdata;
			res_last_q   <= (pop_left_q == '0);
		end
		if (cmd.out_load) begin
			out_data_q   <= res_data_q;
			out_status_q <= res_status_q;
			out_last_q   <= res_last_q;
			out_used_q   <= USED_W'(used);
		end
	end

	assign out_valid  = out_valid_q;
	assign data_out   = out_data_q;
	assign status     = out_status_q;
	assign last       = out_last_q;
	assign used_bytes = out_used_q;

endmodule

// ===== hw/rtl/length_prefixed_byte_ring_queue.sv =====
// Length-prefixed byte ring queue. One item is handled at a time; the controller steps it
// through the single-port ring memory one access at a time, header bytes first for a push
// or pop that opens a message, and then loads the result register. The next item is
// accepted at the same edge as the previous result transfer at the earliest. Reset is
// asynchronous and clears pointers, counters and control state only.
module length_prefixed_byte_ring_queue
	import lpbrq_pkg::*;
#(
	parameter int unsigned CAPACITY     = 4096,
	parameter int unsigned HEADER_BYTES = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                mode,
	input  logic [BYTE_W-1:0]   data_in,
	input  logic [LEN_W-1:0]    msg_length,
	input  logic [LEN_W-1:0]    dest_capacity,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [BYTE_W-1:0]   data_out,
	output logic [STATUS_W-1:0] status,
	output logic                last,
	output logic [USED_W-1:0]   used_bytes
);

	cmd_t cmd;
	sts_t sts;

	// Sequencer for one item's transfer through the ring.
	lpbrq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Pointers, ring memory and result register.
	lpbrq_dp #(
		.CAPACITY     (CAPACITY),
		.HEADER_BYTES (HEADER_BYTES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.mode          (mode),
		.data_in       (data_in),
		.msg_length    (msg_length),
		.dest_capacity (dest_capacity),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.data_out      (data_out),
		.status        (status),
		.last          (last),
		.used_bytes    (used_bytes)
	);

endmodule

// ===== hw/rtl/lpbrq_checker.sv =====
// Port-level checks for the length-prefixed byte ring queue, bound to the top level.
// Depends on lpbrq_pkg for the status codes.
module lpbrq_checker
	import lpbrq_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input logic [BYTE_W-1:0]   data_out,
	input logic [STATUS_W-1:0] status,
	input logic                last
);

	// A new item is never taken while a result is stuck in the output register.
	a_no_accept_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (!out_valid || out_ready))
		else $error("input taken while result transfer is stalled");

	// Only a popped byte carries data.
	a_data_only_on_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status != ST_POPPED)) |-> (data_out == '0))
		else $error("nonzero data on a result that is not a popped byte");

	// Empty and skipped results never close a message.
	a_no_last_on_skip: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && ((status == ST_EMPTY) || (status == ST_TOO_LARGE))) |-> !last)
		else $error("last set on an empty or skipped result");

	// A zero-length push always ends its message.
	a_zero_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == ST_ZERO)) |-> last)
		else $error("zero-length push without last");

	// A stalled result keeps its status.
	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(status)))
		else $error("stalled result changed or dropped");

endmodule

bind length_prefixed_byte_ring_queue lpbrq_checker u_lpbrq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.data_out  (data_out),
	.status    (status),
	.last      (last)
);

// ===== tb/ring_queue_checker.sv =====
// Scoreboard for the length-prefixed byte ring queue: it watches both channels, predicts
// each result from its own copy of the ring and the pointers, and compares field by field.
// Depends on lpbrq_pkg for the field widths and the mode and status codes.
module ring_queue_checker
	import lpbrq_pkg::*;
#(
	parameter int unsigned CAPACITY     = 4096,
	parameter int unsigned HEADER_BYTES = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  logic                mode,
	input  logic [BYTE_W-1:0]   data_in,
	input  logic [LEN_W-1:0]    msg_length,
	input  logic [LEN_W-1:0]    dest_capacity,
	input  logic                out_valid,
	input  logic                out_ready,
	input  logic [BYTE_W-1:0]   data_out,
	input  logic [STATUS_W-1:0] status,
	input  logic                last,
	input  logic [USED_W-1:0]   used_bytes,
	output int unsigned         errors,
	output int unsigned         pending,
	output int unsigned         fill_level
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CELLS = CAPACITY + 1;

	// One predicted result transfer.
	typedef struct packed {
		logic [BYTE_W-1:0]   data;
		logic [STATUS_W-1:0] code;
		logic                fin;
		logic [USED_W-1:0]   fill;
	} reply_t;

	// Shadow of the ring and its pointers.
	logic [BYTE_W-1:0] cells [CELLS];
	int unsigned commit_ptr;
	int unsigned work_ptr;
	int unsigned read_ptr;
	int unsigned push_left;
	int unsigned pop_left;
	bit          push_drop;

	reply_t      owed_replies [$];
	int unsigned err_count = 0;

	function automatic int unsigned wrap_add(input int unsigned p, input int unsigned n);
		return (p + n % CELLS) % CELLS;
	endfunction

	// Committed bytes between the read pointer and the commit pointer.
	function automatic int unsigned committed();
		return (commit_ptr >= read_ptr) ? commit_ptr - read_ptr : commit_ptr + CELLS - read_ptr;
	endfunction

	function automatic void put_byte(input logic [BYTE_W-1:0] b);
		cells[work_ptr] = b;
		work_ptr = wrap_add(work_ptr, 1);
	endfunction

	function automatic logic [BYTE_W-1:0] take_byte();
		logic [BYTE_W-1:0] b;
		b = cells[read_ptr];
		read_ptr = wrap_add(read_ptr, 1);
		return b;
	endfunction

	// Applies one accepted item to the shadow state and returns the result it must produce.
	function automatic reply_t ring_step(input logic m, input logic [BYTE_W-1:0] b,
	                                     input logic [LEN_W-1:0] len,
	                                     input logic [LEN_W-1:0] cap);
		reply_t      r;
		int unsigned size;
		int unsigned i;
		bit          serve;
		r = '0;
		if (m == MODE_PUSH) begin
			if (push_left != 0) begin
				// Later byte of a message: stored or dropped as its first byte decided.
				push_left--;
				if (push_drop) begin
					r.code = ST_FULL;
				end else begin
					put_byte(b);
					r.code = ST_PUSHED;
				end
				if (push_left == 0) begin
					r.fin = 1'b1;
					if (!push_drop)
						commit_ptr = work_ptr;
					push_drop = 1'b0;
				end
			end else if (len == 0) begin
				r.code = ST_ZERO;
				r.fin  = 1'b1;
			end else begin
				// First byte: admit only if header, data and committed bytes fit.
				push_left = len - 1;
				if (HEADER_BYTES + len + committed() > CAPACITY) begin
					r.code    = ST_FULL;
					push_drop = (push_left != 0);
				end else begin
					work_ptr = commit_ptr;
					for (i = 0; i < HEADER_BYTES; i++)
						put_byte(BYTE_W'(len >> (8 * i)));
					put_byte(b);
					r.code = ST_PUSHED;
					if (push_left == 0)
						commit_ptr = work_ptr;
				end
				r.fin = (push_left == 0);
			end
		end else begin
			serve = 1'b1;
			if (pop_left == 0) begin
				if (committed() == 0) begin
					r.code = ST_EMPTY;
					serve  = 1'b0;
				end else begin
					// Read the little-endian header, then skip or open the message.
					size = 0;
					for (i = 0; i < HEADER_BYTES; i++)
						size |= 32'(take_byte()) << (8 * i);
					if (size > cap || size == 0) begin
						read_ptr = wrap_add(read_ptr, size);
						r.code   = ST_TOO_LARGE;
						serve    = 1'b0;
					end else begin
						pop_left = size;
					end
				end
			end
			if (serve) begin
				r.data = take_byte();
				pop_left--;
				r.code = ST_POPPED;
				r.fin  = (pop_left == 0);
			end
		end
		r.fill = USED_W'(committed());
		return r;
	endfunction

	task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
			err_count++;
		end
	endtask

	// Compare a result transfer first, then predict for an item transfer at the same edge.
	always @(posedge clk or negedge arst_n) begin
		reply_t want;
		if (!arst_n) begin
			commit_ptr = 0;
			work_ptr   = 0;
			read_ptr   = 0;
			push_left  = 0;
			pop_left   = 0;
			push_drop  = 1'b0;
			owed_replies.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (owed_replies.size() == 0) begin
					$display("%0t: result with nothing expected, status %0d", $time, status);
					err_count++;
				end else begin
					want = owed_replies.pop_front();
					check_field("data_out", 16'(want.data), 16'(data_out));
					check_field("status", 16'(want.code), 16'(status));
					check_field("last", 16'(want.fin), 16'(last));
					check_field("used_bytes", 16'(want.fill), 16'(used_bytes));
				end
			end
			if (in_valid && in_ready)
				owed_replies.push_back(ring_step(mode, data_in, msg_length, dest_capacity));
		end
		errors     <= err_count;
		pending    <= owed_replies.size();
		fill_level <= committed();
	end

endmodule

// ===== tb/tb.sv =====
// Top of the testbench for the length-prefixed byte ring queue: clock, reset, stimulus and
// verdict. Depends on lpbrq_pkg, the queue RTL and ring_queue_checker.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import lpbrq_pkg::*;

	localparam int unsigned RING_BYTES     = 4096;
	localparam int unsigned HDR_BYTES      = 4;
	localparam int unsigned WATCHDOG_LIMIT = 1000;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic                mode;
	logic [BYTE_W-1:0]   data_in;
	logic [LEN_W-1:0]    msg_length;
	logic [LEN_W-1:0]    dest_capacity;
	logic                out_valid;
	logic                out_ready;
	logic [BYTE_W-1:0]   data_out;
	logic [STATUS_W-1:0] status;
	logic                last;
	logic [USED_W-1:0]   used_bytes;

	int unsigned errors;
	int unsigned pending;
	int unsigned fill_level;

	// Stretches with no idling on either side; bytes still owed to the message being pushed.
	logic        no_idle        = 1'b0;
	int unsigned push_remaining = 0;

	length_prefixed_byte_ring_queue #(
		.CAPACITY     (RING_BYTES),
		.HEADER_BYTES (HDR_BYTES)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.mode          (mode),
		.data_in       (data_in),
		.msg_length    (msg_length),
		.dest_capacity (dest_capacity),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.data_out      (data_out),
		.status        (status),
		.last          (last),
		.used_bytes    (used_bytes)
	);

	ring_queue_checker #(
		.CAPACITY     (RING_BYTES),
		.HEADER_BYTES (HDR_BYTES)
	) watch (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.mode          (mode),
		.data_in       (data_in),
		.msg_length    (msg_length),
		.dest_capacity (dest_capacity),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.data_out      (data_out),
		.status        (status),
		.last          (last),
		.used_bytes    (used_bytes),
		.errors        (errors),
		.pending       (pending),
		.fill_level    (fill_level)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Offers one item after a random gap and returns at the edge of its transfer.
	task automatic offer(input logic m, input logic [BYTE_W-1:0] b,
	                     input logic [LEN_W-1:0] len, input logic [LEN_W-1:0] cap);
		int unsigned gap;
		if ($urandom_range(0, 99) == 0)
			no_idle <= !no_idle;
		gap = no_idle ? 0 : $urandom_range(0, 18);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		mode          <= m;
		data_in       <= b;
		msg_length    <= len;
		dest_capacity <= cap;
		do @(posedge clk); while (!in_ready);
		if (m == MODE_PUSH) begin
			if (push_remaining != 0)
				push_remaining--;
			else if (len != 0)
				push_remaining = len - 1;
		end
	endtask

	// Random traffic: pops, continuations of the open push, and new messages of small sizes.
	task automatic random_op(input int unsigned pop_pct);
		int unsigned      r;
		logic [LEN_W-1:0] pick;
		r = $urandom_range(0, 99);
		if (r < pop_pct) begin
			r = $urandom_range(0, 99);
			if (r < 25)
				pick = LEN_W'($urandom_range(0, 12));
			else if (r < 35)
				pick = '1;
			else
				pick = LEN_W'($urandom);
			offer(MODE_POP, BYTE_W'($urandom), LEN_W'($urandom), pick);
		end else if (push_remaining != 0) begin
			offer(MODE_PUSH, BYTE_W'($urandom), LEN_W'($urandom), LEN_W'($urandom));
		end else begin
			r = $urandom_range(0, 99);
			if (r < 5)
				pick = '0;
			else if (r < 85)
				pick = LEN_W'($urandom_range(1, 12));
			else
				pick = LEN_W'($urandom_range(13, 80));
			offer(MODE_PUSH, BYTE_W'($urandom), pick, LEN_W'($urandom));
		end
	endtask

	// Drops valid and waits until every predicted result has been transferred.
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// Stimulus and verdict.
	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		mode          = MODE_PUSH;
		data_in       = '0;
		msg_length    = '0;
		dest_capacity = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Empty ring, zero length, one-byte and two-byte messages.
		offer(MODE_POP, 8'h00, 12'd0, 12'hFFF);
		offer(MODE_PUSH, 8'hFF, 12'd0, 12'd0);
		offer(MODE_PUSH, 8'hFF, 12'd1, 12'hFFF);
		offer(MODE_PUSH, 8'h00, 12'd2, 12'd0);
		offer(MODE_PUSH, 8'hA5, 12'hFFF, 12'hFFF);
		// Skip with the smallest limit, then a limit equal to the size, ignored mid-message.
		offer(MODE_POP, 8'hFF, 12'hFFF, 12'd0);
		offer(MODE_POP, 8'h00, 12'd0, 12'd2);
		offer(MODE_POP, 8'h00, 12'd0, 12'd0);
		offer(MODE_POP, 8'h00, 12'd0, 12'hFFF);
		// A message being pushed stays invisible to pops until its last byte.
		offer(MODE_PUSH, 8'h01, 12'd3, 12'd0);
		offer(MODE_POP, 8'h00, 12'd0, 12'hFFF);
		offer(MODE_PUSH, 8'h02, 12'd0, 12'd0);
		offer(MODE_POP, 8'h00, 12'd0, 12'd3);
		offer(MODE_PUSH, 8'h03, 12'd7, 12'd0);
		offer(MODE_PUSH, 8'h04, 12'd2, 12'd0);
		offer(MODE_POP, 8'h00, 12'd0, 12'd2);
		offer(MODE_PUSH, 8'h05, 12'd0, 12'd0);
		offer(MODE_POP, 8'h00, 12'd0, 12'hFFF);
		offer(MODE_POP, 8'h00, 12'd0, 12'hFFF);
		offer(MODE_POP, 8'h00, 12'd0, 12'hFFF);

		repeat (100) random_op(45);

		// Finish the open message and drain the ring by skipping whole messages.
		while (push_remaining != 0)
			offer(MODE_PUSH, BYTE_W'($urandom), LEN_W'($urandom), LEN_W'($urandom));
		settle();
		while (fill_level != 0) begin
			offer(MODE_POP, BYTE_W'($urandom), LEN_W'($urandom), 12'd0);
			settle();
		end

		// Refill from empty: a message whose length needs two header bytes, then one-byte
		// messages, then a two-byte message that leaves the ring exactly full.
		offer(MODE_PUSH, BYTE_W'($urandom), 12'd261, LEN_W'($urandom));
		while (push_remaining != 0)
			offer(MODE_PUSH, BYTE_W'($urandom), LEN_W'($urandom), LEN_W'($urandom));
		repeat (765)
			offer(MODE_PUSH, BYTE_W'($urandom), 12'd1, LEN_W'($urandom));
		offer(MODE_PUSH, BYTE_W'($urandom), 12'd2, LEN_W'($urandom));
		while (push_remaining != 0)
			offer(MODE_PUSH, BYTE_W'($urandom), LEN_W'($urandom), LEN_W'($urandom));
		// Full ring drops a one-byte and a three-byte message; zero length still answers.
		offer(MODE_PUSH, BYTE_W'($urandom), 12'd1, LEN_W'($urandom));
		offer(MODE_PUSH, BYTE_W'($urandom), 12'd3, LEN_W'($urandom));
		while (push_remaining != 0)
			offer(MODE_PUSH, BYTE_W'($urandom), LEN_W'($urandom), LEN_W'($urandom));
		offer(MODE_PUSH, BYTE_W'($urandom), 12'd0, LEN_W'($urandom));
		// Open the long message with a limit equal to its size, then mostly pop.
		offer(MODE_POP, BYTE_W'($urandom), LEN_W'($urandom), 12'd261);
		repeat (60) random_op(75);

		settle();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

	// Result side: random stall before each transfer.
	initial begin
		int unsigned hold;
		out_ready = 1'b0;
		forever begin
			hold = no_idle ? 0 : $urandom_range(0, 18);
			if (hold != 0) begin
				out_ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	// Watchdog: ends the run after too many edges without any transfer.
	initial begin
		int unsigned idle_edges;
		idle_edges = 0;
		while (idle_edges < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_edges = 0;
			else
				idle_edges++;
		end
		$display("tb NOT OK");
		$finish;
	end

endmodule
